[hw/rtl/battery_voltage_to_percent_defines.svh]
// assertion macros for the battery voltage to percent block
// used by files that assert; expects clk and rst in scope

`ifndef BATTERY_VOLTAGE_TO_PERCENT_DEFINES_SVH
`define BATTERY_VOLTAGE_TO_PERCENT_DEFINES_SVH

// same-cycle implication, off during reset
`define BV2PCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define BV2PCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bv2pct_pkg.sv]
// shared constants, curve tables and stage control type
// no dependencies

package bv2pct_pkg;

  localparam int MvW       = 13;
  localparam int PctW      = 7;
  localparam int NumPoints = 12;
  localparam int SegW      = 4;
  localparam int OffW      = 8;   // widest segment span is 230 mV
  localparam int CoefW     = 20;
  localparam int FracBits  = 20;
  localparam int ProdW     = OffW + CoefW;
  localparam int QuotW     = ProdW - FracBits;

  localparam logic [PctW-1:0] PctMax = 7'd100;
  localparam logic [PctW-1:0] PctMin = 7'd0;

  // breakpoints of the discharge curve
  localparam logic [MvW-1:0] CurveMv [NumPoints] = '{
    13'd3300, 13'd3450, 13'd3680, 13'd3740, 13'd3770, 13'd3790,
    13'd3820, 13'd3870, 13'd3920, 13'd3980, 13'd4060, 13'd4200
  };

  localparam logic [PctW-1:0] CurvePct [NumPoints] = '{
    7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40,
    7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
  };

  // per segment: percent span times ceil(2^20 / mV span), so that
  // (offset * coef) >> 20 equals the truncated quotient exactly
  // for every offset in the segment; entry 0 has no segment
  localparam logic [CoefW-1:0] SegCoef [NumPoints] = '{
    20'd0,      20'd34955,  20'd22800,  20'd174770,
    20'd349530, 20'd524290, 20'd349530, 20'd209720,
    20'd209720, 20'd174770, 20'd131080, 20'd74900
  };

  // load enables of the four pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

[hw/rtl/bv2pct_if.sv]
// handshake channels for voltage words in and percent words out
// depends on bv2pct_pkg

interface bv2pct_mv_if;
  logic                           valid;
  logic                           ready;
  logic [bv2pct_pkg::MvW-1:0]     millivolts;

  modport source (output valid, output millivolts, input ready);
  modport sink (input valid, input millivolts, output ready);
endinterface

interface bv2pct_pct_if;
  logic                           valid;
  logic                           ready;
  logic [bv2pct_pkg::PctW-1:0]    percent;

  modport source (output valid, output percent, input ready);
  modport sink (input valid, input percent, output ready);
endinterface

[hw/rtl/bv2pct_core.sv]
// four-stage interpolation datapath: compare, offset, multiply, add
// depends on bv2pct_pkg; stage enables come from the top level

module bv2pct_core (
  input  logic                          clk,
  input  bv2pct_pkg::stage_en_t         en,
  input  logic [bv2pct_pkg::MvW-1:0]    millivolts,
  output logic [bv2pct_pkg::PctW-1:0]   percent
);

  // stage 1 registers
  logic [bv2pct_pkg::MvW-1:0]       mv1;
  logic [bv2pct_pkg::NumPoints-1:0] above1;
  logic [bv2pct_pkg::NumPoints-1:0] above_next;

  // stage 2 registers
  logic [bv2pct_pkg::OffW-1:0]      off2;
  logic [bv2pct_pkg::CoefW-1:0]     coef2;
  logic [bv2pct_pkg::PctW-1:0]      base2;

  // stage 3 registers
  logic [bv2pct_pkg::ProdW-1:0]     prod3;
  logic [bv2pct_pkg::PctW-1:0]      base3;

  // stage 4 register
  logic [bv2pct_pkg::PctW-1:0]      pct4;

  // stage 2 helpers
  logic [bv2pct_pkg::SegW-1:0]      cnt;
  logic [bv2pct_pkg::SegW-1:0]      idx;
  logic                             sat_lo;
  logic                             sat_hi;
  logic [bv2pct_pkg::MvW-1:0]       diff;

  // compare against every breakpoint
  always_comb begin
    for (int i = 0; i < bv2pct_pkg::NumPoints; i++) begin
      above_next[i] = millivolts > bv2pct_pkg::CurveMv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      mv1    <= millivolts;
      above1 <= above_next;
    end
  end

  // segment index is the number of breakpoints below the input
  always_comb begin
    cnt = '0;
    for (int i = 0; i < bv2pct_pkg::NumPoints; i++) begin
      cnt = cnt + bv2pct_pkg::SegW'(above1[i]);
    end
    sat_lo = (cnt == '0);
    sat_hi = (cnt == bv2pct_pkg::SegW'(bv2pct_pkg::NumPoints));
    idx    = (sat_lo || sat_hi) ? bv2pct_pkg::SegW'(1) : cnt;
    diff   = mv1 - bv2pct_pkg::CurveMv[idx - bv2pct_pkg::SegW'(1)];
  end

  // offset into the segment, scale and base percent
  always_ff @(posedge clk) begin
    if (en.s2) begin
      off2  <= (sat_lo || sat_hi) ? '0 : diff[bv2pct_pkg::OffW-1:0];
      coef2 <= bv2pct_pkg::SegCoef[idx];
      if (sat_hi) begin
        base2 <= bv2pct_pkg::PctMax;
      end else if (sat_lo) begin
        base2 <= bv2pct_pkg::PctMin;
      end else begin
        base2 <= bv2pct_pkg::CurvePct[idx - bv2pct_pkg::SegW'(1)];
      end
    end
  end

  // scaled offset
  always_ff @(posedge clk) begin
    if (en.s3) begin
      prod3 <= bv2pct_pkg::ProdW'(off2) * bv2pct_pkg::ProdW'(coef2);
      base3 <= base2;
    end
  end

  // quotient plus base percent
  always_ff @(posedge clk) begin
    if (en.s4) begin
      pct4 <= base3 + bv2pct_pkg::PctW'(prod3[bv2pct_pkg::ProdW-1:bv2pct_pkg::FracBits]);
    end
  end

  assign percent = pct4;

endmodule

[hw/rtl/battery_voltage_to_percent.sv]
// top level: battery voltage to state-of-charge percent, valid/ready control
// depends on bv2pct_pkg, bv2pct_if, bv2pct_core and the defines header

// Takes one voltage word per cycle unless held by a stalled output, and returns
// the state of charge in whole percent on a 12-point discharge curve, 0 at or
// below 3300 mV and 100 above 4200 mV, interpolated with truncation in between.
// Throughput is one word per clock unless held by a stalled output. Words pass
// through four register stages (breakpoint compare, segment offset,
// reciprocal multiply, final add), the first of which loads at acceptance.
// Each stage holds its word when the next one is full and cannot move on,
// so bubbles are squeezed out and a stalled output only blocks the input
// once all four stages are occupied.

`include "battery_voltage_to_percent_defines.svh"

module battery_voltage_to_percent (
  input  logic          clk,
  input  logic          rst,
  bv2pct_mv_if.sink     voltage,
  bv2pct_pct_if.source  charge
);

  logic v1;
  logic v2;
  logic v3;
  logic v4;

  // assertion helpers
  logic in_take;
  logic full_stall;
  logic pct_in_range;

  bv2pct_pkg::stage_en_t en;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    en.s4 = !v4 || charge.ready;
    en.s3 = !v3 || en.s4;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
  end

  assign voltage.ready = en.s1;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.s1) v1 <= voltage.valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en.s4) v4 <= v3;
    end
  end

  bv2pct_core u_core (
    .clk        (clk),
    .en         (en),
    .millivolts (voltage.millivolts),
    .percent    (charge.percent)
  );

  assign charge.valid = v4;

  // checks
  assign in_take      = voltage.valid && voltage.ready;
  assign full_stall   = v1 && v2 && v3 && v4 && !charge.ready;
  assign pct_in_range = charge.percent <= bv2pct_pkg::PctMax;

  `BV2PCT_ASSERT_NOW(a_pct_range, charge.valid, pct_in_range, "percent above 100")
  `BV2PCT_ASSERT_NOW(a_empty_ready, !charge.valid, voltage.ready, "input blocked while empty")
  `BV2PCT_ASSERT_NOW(a_full_stall, full_stall, !voltage.ready, "input taken while stalled")
  `BV2PCT_ASSERT_NEXT(a_accept_lands, in_take, v1, "accepted word lost at stage one")

endmodule
